@@ hw/rtl/tmt_pkg.sv @@
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types and constants of the 32-bit tiny Mersenne twister generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmt_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word w0;
        t_word w1;
        t_word w2;
        t_word w3;
    } t_state;

    localparam t_word LOW31      = 32'h7fff_ffff;
    localparam t_word MIX_MULT   = 32'd1812433253;
    localparam t_word RESET_M1   = 32'h8f70_11ee;
    localparam t_word RESET_M2   = 32'hfc78_ff1f;
    localparam t_word RESET_TM   = 32'h3793_fdff;

    // fallback state for a mixed state that is zero but for bit 31 of w0 ("TINY")
    localparam t_word CERT_W0    = 32'h0000_0054;
    localparam t_word CERT_W1    = 32'h0000_0049;
    localparam t_word CERT_W2    = 32'h0000_004e;
    localparam t_word CERT_W3    = 32'h0000_0059;

    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_RESEED   = 1'b1;

    localparam logic [1:0] REG_MATRIX_ONE  = 2'd0;
    localparam logic [1:0] REG_MATRIX_TWO  = 2'd1;
    localparam logic [1:0] REG_TEMPER_MASK = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/tmt_in_if.sv @@
// ----------------------------------------------------------------------------
// tmt_in_if
// Command channel: valid/ready handshake carrying command and seed.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmt_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] seed;

    modport source (output valid, output command, output seed, input ready);
    modport sink   (input valid, input command, input seed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tmt_out_if.sv @@
// ----------------------------------------------------------------------------
// tmt_out_if
// Result channel: valid/ready handshake carrying one tempered word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tmt_advance.sv @@
// ----------------------------------------------------------------------------
// tmt_advance
// One state advance: xor-shift feedback plus conditional matrix masks.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_advance
    import tmt_pkg::*;
(
    input  var t_state i_state,
    input  var t_word  i_matrix_one,
    input  var t_word  i_matrix_two,
    output t_state     o_state
);

    t_word x0;
    t_word x1;
    t_word y;

    always_comb begin
        x0 = (i_state.w0 & LOW31) ^ i_state.w1 ^ i_state.w2;
        x1 = x0 ^ (x0 << 1);
        y  = i_state.w3 ^ (i_state.w3 >> 1) ^ x1;

        o_state.w0 = i_state.w1;
        o_state.w1 = i_state.w2 ^ (y[0] ? i_matrix_one : '0);
        o_state.w2 = x1 ^ (y << 10) ^ (y[0] ? i_matrix_two : '0);
        o_state.w3 = y;
    end

endmodule

`default_nettype wire

@@ hw/rtl/tinymt32_random_generator.sv @@
// Generate: after the transfer the state is advanced (S_GEN), then tempered into
//   the output register (S_TEMP) once it is free; no new command until then.
// Reseed: 7 mixing steps (S_MUL, S_ADD) on the single 32x32 multiplier, a
//   certification step (S_CERT) and 8 advances (S_ADV), busy all the while.
// Reset: all registers but r_prod and r_out take their defaults and the
//   seed-zero reseed runs, so commands are accepted once it has finished.
// ----------------------------------------------------------------------------
// tinymt32_random_generator
// Tiny Mersenne twister with 128-bit state, a multi-cycle reseed sequencer
// and a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module tinymt32_random_generator
    import tmt_pkg::*;
(
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    tmt_in_if.sink    i_cmd,
    tmt_out_if.source o_rnd,
    input  var logic        i_cfg_we,
    input  var logic [1:0]  i_cfg_idx,
    input  var logic [31:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_CERT = 3'd3;
    localparam logic [2:0] S_ADV  = 3'd4;
    localparam logic [2:0] S_GEN  = 3'd5;
    localparam logic [2:0] S_TEMP = 3'd6;

    logic [2:0] r_fsm, n_fsm;
    logic [2:0] r_cnt, n_cnt;
    t_state     r_st, n_st;
    t_word      r_prod, n_prod;
    t_word      r_m1, r_m2, r_tm;
    t_word      r_out, n_out;
    logic       r_out_valid, n_out_valid;

    t_state     adv_st;
    t_word      mix_in;
    t_word      sum;
    t_word      tempered;
    t_state     rot;
    logic       cmd_xfer;
    logic       out_free;

    tmt_advance u_adv (
        .i_state      (r_st),
        .i_matrix_one (r_m1),
        .i_matrix_two (r_m2),
        .o_state      (adv_st)
    );

    assign i_cmd.ready        = (r_fsm == S_IDLE);
    assign cmd_xfer           = i_cmd.valid && (r_fsm == S_IDLE);
    assign o_rnd.valid        = r_out_valid;
    assign o_rnd.random_value = r_out;
    assign out_free           = !r_out_valid || o_rnd.ready;

    always_comb begin
        // words are kept rotated during mixing: previous word in w0, target in w1
        mix_in   = r_st.w0 ^ (r_st.w0 >> 30);
        sum      = r_st.w0 + (r_st.w2 >> 8);
        tempered = r_st.w3 ^ sum ^ (sum[0] ? r_tm : '0);
        rot.w0   = r_st.w1;
        rot.w1   = r_st.w2;
        rot.w2   = r_st.w3;
        rot.w3   = r_st.w0;

        n_fsm       = r_fsm;
        n_cnt       = r_cnt;
        n_st        = r_st;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rnd.ready;

        case (r_fsm)
            S_IDLE: begin
                if (cmd_xfer) begin
                    if (i_cmd.command == CMD_RESEED) begin
                        n_st  = '{w0: i_cmd.seed, w1: r_m1, w2: r_m2, w3: r_tm};
                        n_cnt = 3'd1;
                        n_fsm = S_MUL;
                    end else begin
                        n_fsm = S_GEN;
                    end
                end
            end
            S_MUL: begin
                n_prod = 32'(MIX_MULT * mix_in);
                n_fsm  = S_ADD;
            end
            S_ADD: begin
                n_st    = rot;
                n_st.w0 = r_st.w1 ^ ({29'd0, r_cnt} + r_prod);
                n_cnt   = r_cnt + 3'd1;
                n_fsm   = (r_cnt == 3'd7) ? S_CERT : S_MUL;
            end
            S_CERT: begin
                // after seven rotations one more puts word 0 back in place
                if (((rot.w0 & LOW31) == '0) && (rot.w1 == '0) &&
                    (rot.w2 == '0) && (rot.w3 == '0)) begin
                    n_st = '{w0: CERT_W0, w1: CERT_W1, w2: CERT_W2, w3: CERT_W3};
                end else begin
                    n_st = rot;
                end
                n_cnt = 3'd0;
                n_fsm = S_ADV;
            end
            S_ADV: begin
                n_st  = adv_st;
                n_cnt = r_cnt + 3'd1;
                n_fsm = (r_cnt == 3'd7) ? S_IDLE : S_ADV;
            end
            S_GEN: begin
                n_st  = adv_st;
                n_fsm = S_TEMP;
            end
            S_TEMP: begin
                if (out_free) begin
                    n_out       = tempered;
                    n_out_valid = 1'b1;
                    n_fsm       = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_MUL;
            r_cnt       <= 3'd1;
            r_st        <= '{w0: '0, w1: RESET_M1, w2: RESET_M2, w3: RESET_TM};
            r_out_valid <= 1'b0;
            r_m1        <= RESET_M1;
            r_m2        <= RESET_M2;
            r_tm        <= RESET_TM;
        end else begin
            r_fsm       <= n_fsm;
            r_cnt       <= n_cnt;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MATRIX_ONE:  r_m1 <= i_cfg_data;
                    REG_MATRIX_TWO:  r_m2 <= i_cfg_data;
                    REG_TEMPER_MASK: r_tm <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire
